// ===== hdl/rgbyc_pkg.sv =====
`default_nettype none

package rgbyc_pkg;

   // Request operation codes
   localparam logic OP_CONVERT   = 1'b0;
   localparam logic OP_PAL_WRITE = 1'b1;

   // Register file: byte addresses, one 32-bit word per register
   localparam int unsigned CSR_ADDR_W       = 3;
   localparam int unsigned CSR_DATA_W       = 32;
   localparam logic        REG_PALETTE_MODE = 1'b0;   // word index of palette_mode

   // One converted colour
   typedef struct packed {
      logic [7:0] y;
      logic [7:0] cb;
      logic [7:0] cr;
   } colour_type;

   // Palette write command from the pipeline to the palette store
   typedef struct packed {
      logic       en;
      logic [7:0] index;
      colour_type colour;
   } pal_wr_type;

   // Integer RGB -> YCbCr. The 32768 bias keeps the chroma sums non-negative,
   // so bits 15:8 are the floored quotient plus 128.
   function automatic colour_type convert_colour(input logic [7:0] r,
                                                 input logic [7:0] g,
                                                 input logic [7:0] b);
      logic [16:0] y_sum;
      logic [16:0] cb_sum;
      logic [16:0] cr_sum;
      colour_type  c;
      y_sum  = 17'd76 * 17'(r) + 17'd148 * 17'(g) + 17'd29 * 17'(b);
      cb_sum = 17'd32768 + 17'd128 * 17'(b) - 17'd43 * 17'(r) - 17'd85 * 17'(g);
      cr_sum = 17'd32768 + 17'd128 * 17'(r) - 17'd107 * 17'(g) - 17'd21 * 17'(b);
      c.y  = y_sum[15:8];
      c.cb = cb_sum[15:8];
      c.cr = cr_sum[15:8];
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/rgbyc_if.sv =====
`default_nettype none

// Pixel / palette-write request channel
interface rgbyc_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [15:0] pixel;
   logic        row_start;
   logic [7:0]  entry_index;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;

   modport source (output valid, operation, pixel, row_start, entry_index,
                   red, green, blue, input ready);
   modport sink   (input valid, operation, pixel, row_start, entry_index,
                   red, green, blue, output ready);
endinterface

// Packed 4:2:2 pair channel (Cb Y0 Cr Y1)
interface rgbyc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] chroma_blue;
   logic [7:0] luma_even;
   logic [7:0] chroma_red;
   logic [7:0] luma_odd;

   modport source (output valid, chroma_blue, luma_even, chroma_red, luma_odd,
                   input ready);
   modport sink   (input valid, chroma_blue, luma_even, chroma_red, luma_odd,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/rgbyc_palette.sv =====
`default_nettype none

// Palette store: one write and one registered read per cycle.
// Per-entry valid bits make unwritten entries read as zero right after reset.
module rgbyc_palette #(
   parameter int unsigned ENTRIES = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rgbyc_pkg::pal_wr_type  wr,
   input  wire logic                   rd_en,
   input  wire logic [7:0]             rd_index,
   output rgbyc_pkg::colour_type       rd_colour
);
   import rgbyc_pkg::*;

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   colour_type         mem [ENTRIES];
   logic [ENTRIES-1:0] entry_valid_ff;
   colour_type         rd_data_ff;
   logic               rd_hit_ff;

   logic wr_in_range;
   logic rd_in_range;

   assign wr_in_range = ({1'b0, wr.index} < 9'(ENTRIES));
   assign rd_in_range = ({1'b0, rd_index} < 9'(ENTRIES));

   // Storage write
   always_ff @(posedge clock) begin
      if (wr.en && wr_in_range) begin
         mem[wr.index[IDX_W-1:0]] <= wr.colour;
      end
   end

   // Valid bits, cleared together at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (wr.en && wr_in_range) begin
         entry_valid_ff[wr.index[IDX_W-1:0]] <= 1'b1;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_index[IDX_W-1:0]];
         rd_hit_ff  <= rd_in_range && entry_valid_ff[rd_index[IDX_W-1:0]];
      end
   end

   assign rd_colour = rd_hit_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

// ===== hdl/rgb_to_ycbcr422_packer.sv =====
`default_nettype none

// Channel   Dir  Handshake            Payload
// req_bus   in   valid/ready          operation, pixel, row_start, entry_index, rgb
// rsp_bus   out  valid/ready          chroma_blue, luma_even, chroma_red, luma_odd
// csr_*     in   APB write/read       palette_mode at byte address 0
//
// One request per clock while req_bus.ready is high. After its odd pixel is accepted,
// a pair passes the input register, palette read / RGB565 convert, result register.
// A stalled result holds the whole pipeline; req_bus.ready follows rsp_bus.ready
// while the result register is full.
// Reset is synchronous; the palette valid bits clear together, no sweep.
module rgb_to_ycbcr422_packer #(
   parameter int unsigned PALETTE_ENTRIES = 256
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   rgbyc_req_if.sink                            req_bus,
   rgbyc_rsp_if.source                          rsp_bus,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [rgbyc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [rgbyc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output      logic [rgbyc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output      logic                            csr_pready
);
   import rgbyc_pkg::*;

   // Control and config
   logic palette_mode_ff;
   logic advance;
   logic req_fire;

   // Stage 1: input register
   logic        s1_valid_ff;
   logic        s1_op_ff;
   logic [15:0] s1_pixel_ff;
   logic        s1_row_ff;
   logic [7:0]  s1_index_ff;
   logic [7:0]  s1_red_ff;
   logic [7:0]  s1_green_ff;
   logic [7:0]  s1_blue_ff;

   // Stage 2: converted colour
   logic        s2_valid_ff;
   logic        s2_op_ff;
   logic        s2_row_ff;
   colour_type  s2_rgb_ff;
   colour_type  s2_rgb_in;
   colour_type  pal_colour;
   colour_type  s2_colour;
   pal_wr_type  pal_wr;

   // Pairing state
   logic        odd_phase_ff;
   logic        odd_phase_in;
   colour_type  held_ff;
   logic        s2_pixel;
   logic        pair_done;

   // Result register
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [7:0]  out_cb_ff;
   logic [7:0]  out_y0_ff;
   logic [7:0]  out_cr_ff;
   logic [7:0]  out_y1_ff;

   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;
   assign req_fire      = req_bus.valid && advance;

   // Configuration port
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_mode_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[CSR_ADDR_W-1:2] == REG_PALETTE_MODE) begin
         palette_mode_ff <= csr_pwdata[0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1:2] == REG_PALETTE_MODE) begin
         csr_prdata[0] = palette_mode_ff;
      end
   end

   // Stage 1 capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff    <= req_bus.operation;
         s1_pixel_ff <= req_bus.pixel;
         s1_row_ff   <= req_bus.row_start;
         s1_index_ff <= req_bus.entry_index;
         s1_red_ff   <= req_bus.red;
         s1_green_ff <= req_bus.green;
         s1_blue_ff  <= req_bus.blue;
      end
   end

   // Stage 1 work: palette write, palette read, RGB565 convert
   assign pal_wr.en     = advance && s1_valid_ff && (s1_op_ff == OP_PAL_WRITE);
   assign pal_wr.index  = s1_index_ff;
   assign pal_wr.colour = convert_colour(s1_red_ff, s1_green_ff, s1_blue_ff);

   assign s2_rgb_in = convert_colour({s1_pixel_ff[15:11], 3'b000},
                                     {s1_pixel_ff[10:5], 2'b00},
                                     {s1_pixel_ff[4:0], 3'b000});

   rgbyc_palette #(
      .ENTRIES (PALETTE_ENTRIES)
   ) u_palette (
      .clock     (clock),
      .reset     (reset),
      .wr        (pal_wr),
      .rd_en     (advance),
      .rd_index  (s1_pixel_ff[7:0]),
      .rd_colour (pal_colour)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_op_ff  <= s1_op_ff;
         s2_row_ff <= s1_row_ff;
         s2_rgb_ff <= s2_rgb_in;
      end
   end

   // Stage 2: pick the colour and pair pixels
   assign s2_colour = palette_mode_ff ? pal_colour : s2_rgb_ff;
   assign s2_pixel  = advance && s2_valid_ff && (s2_op_ff == OP_CONVERT);
   assign pair_done = s2_pixel && odd_phase_ff && !s2_row_ff;

   always_comb begin
      odd_phase_in = odd_phase_ff;
      if (s2_pixel) begin
         odd_phase_in = !pair_done;
      end
   end

   assign out_valid_in = advance ? pair_done : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         odd_phase_ff <= 1'b0;
         held_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         odd_phase_ff <= odd_phase_in;
         out_valid_ff <= out_valid_in;
         if (s2_pixel && !pair_done) begin
            held_ff <= s2_colour;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (pair_done) begin
         out_cb_ff <= held_ff.cb;
         out_y0_ff <= held_ff.y;
         out_cr_ff <= held_ff.cr;
         out_y1_ff <= s2_colour.y;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.chroma_blue = out_cb_ff;
   assign rsp_bus.luma_even   = out_y0_ff;
   assign rsp_bus.chroma_red  = out_cr_ff;
   assign rsp_bus.luma_odd    = out_y1_ff;

   // Checks
   a_pair_emits : assert property (@(posedge clock) disable iff (reset)
      pair_done |=> out_valid_ff)
      else $error("completed pair did not reach the result register");

   a_even_arms_odd : assert property (@(posedge clock) disable iff (reset)
      (s2_pixel && !pair_done) |=> (odd_phase_ff && !out_valid_ff))
      else $error("even pixel did not arm odd phase or emitted a result");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !s2_valid_ff && !out_valid_ff && !odd_phase_ff))
      else $error("pipeline not empty after reset");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready) |=> ($stable(odd_phase_ff) && $stable(held_ff)))
      else $error("pairing state moved while the result was stalled");

endmodule

`default_nettype wire
